/* design/largest_prime_at_most_core_defines.svh */
// assertion macros shared by the largest prime search design
`ifndef LARGEST_PRIME_AT_MOST_CORE_DEFINES_SVH
`define LARGEST_PRIME_AT_MOST_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define LPAM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define LPAM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/lpam_pkg.sv */
// shared constants and types for the largest prime search design
package lpam_pkg;

    localparam int LPAM_VALUE_WIDTH = 16;

    // status from the remainder unit back to the search sequencer
    typedef struct packed {
        logic done;
        logic zero;
    } rem_stat_t;

endpackage

/* design/largest_prime_at_most_core.sv */
// largest prime not above a limit, by trial division over a bit-serial remainder unit
//
//  channel  | ports                        | handshake
//  ---------+------------------------------+------------------------------
//  request  | upper_limit                  | taken when start & !busy
//  result   | largest_prime                | valid for one cycle with done
//
// each candidate is checked in the check state once per divisor, with a bit-serial trial
// remainder in the divide state; divisors run from 2 while d*d <= candidate, and
// candidates run down from the limit until a prime is found (a limit below 2 gives 1).
// reset is asynchronous and leaves the block idle; done must be taken when shown.
`include "largest_prime_at_most_core_defines.svh"

module largest_prime_at_most_core
    import lpam_pkg::*;
#(
    parameter int VALUE_WIDTH = LPAM_VALUE_WIDTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [VALUE_WIDTH-1:0] upper_limit,
    output logic                   done,
    output logic [VALUE_WIDTH-1:0] largest_prime
);

    localparam int W  = VALUE_WIDTH;
    localparam int DW = (W + 1) / 2 + 1;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_CHECK = 3'b010,
        ST_DIV   = 3'b100
    } state_t;

    state_t        state_reg, state_next;
    logic [W-1:0]  cand_reg, cand_next;
    logic [DW-1:0] dvs_reg, dvs_next;
    logic [W:0]    sq_reg, sq_next;
    logic          done_reg, done_next;
    logic [W-1:0]  res_reg, res_next;
    logic          rem_go;
    rem_stat_t     rem_stat;

    lpam_rem #(
        .WIDTH (W)
    ) u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (rem_go),
        .dividend (cand_reg),
        .divisor  (W'(dvs_reg)),
        .stat     (rem_stat)
    );

    always_comb
    begin
        state_next = state_reg;
        cand_next  = cand_reg;
        dvs_next   = dvs_reg;
        sq_next    = sq_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        rem_go     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cand_next  = upper_limit;
                    dvs_next   = DW'(2);
                    sq_next    = (W + 1)'(4);
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (cand_reg < W'(2))
                begin
                    res_next   = W'(1);
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (sq_reg > (W + 1)'(cand_reg))
                begin
                    // no divisor up to the square root: prime
                    res_next   = cand_reg;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    rem_go     = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (rem_stat.done)
                begin
                    state_next = ST_CHECK;
                    if (rem_stat.zero)
                    begin
                        // composite: move to the next lower candidate
                        cand_next = cand_reg - 1'b1;
                        dvs_next  = DW'(2);
                        sq_next   = (W + 1)'(4);
                    end
                    else
                    begin
                        // (d+1)^2 = d^2 + 2d + 1
                        dvs_next = dvs_reg + 1'b1;
                        sq_next  = sq_reg + (W + 1)'({dvs_reg, 1'b1});
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg <= cand_next;
        dvs_reg  <= dvs_next;
        sq_reg   <= sq_next;
        res_reg  <= res_next;
    end

    assign busy          = (state_reg != ST_IDLE);
    assign done          = done_reg;
    assign largest_prime = res_reg;

    `LPAM_ASSERT_SAME(a_result_odd, done, (largest_prime == W'(2)) || largest_prime[0],
        "result word is even and not two")
    `LPAM_ASSERT_NEXT(a_start_busy, start && !busy, busy && !done,
        "accepted word did not start a search")
    `LPAM_ASSERT_SAME(a_done_idle, done, !busy,
        "result strobe while search still running")
    `LPAM_ASSERT_SAME(a_rem_in_div, rem_stat.done, state_reg == ST_DIV,
        "remainder finished outside the divide state")

endmodule

/* design/lpam_rem.sv */
// bit-serial restoring remainder unit, one dividend bit per cycle
module lpam_rem
    import lpam_pkg::*;
#(
    parameter int WIDTH = LPAM_VALUE_WIDTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output rem_stat_t        stat
);

    localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] div_reg, div_next;
    logic [WIDTH:0]   part;

    // bring down the next dividend bit and try one subtract
    assign part = {rem_reg, quo_reg[WIDTH-1]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (go)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[WIDTH-2:0], 1'b0};
            if (part >= {1'b0, div_reg})
                rem_next = WIDTH'(part - {1'b0, div_reg});
            else
                rem_next = part[WIDTH-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign stat.done = done_reg;
    assign stat.zero = (rem_reg == '0);

endmodule

/* tb/tb_largest_prime_at_most_core.sv */
// self-checking testbench for the largest prime search core
`timescale 1ns / 1ps

module tb_largest_prime_at_most_core;

    import lpam_pkg::*;

    localparam int W            = LPAM_VALUE_WIDTH;
    localparam int CYCLE_LIMIT  = 5000000;
    localparam int RANDOM_WORDS = 100;
    localparam int DRAIN_CYCLES = 40;
    localparam int N_DIRECTED   = 20;

    typedef struct {
        logic [W-1:0] limit;
        bit           known;
        logic [W-1:0] prime;
    } limit_case_t;

    // rows marked known carry a result that is plain from the definition
    limit_case_t directed_cases [N_DIRECTED] = '{
        '{16'd0,     1'b1, 16'd1},
        '{16'd1,     1'b1, 16'd1},
        '{16'd2,     1'b1, 16'd2},
        '{16'd3,     1'b1, 16'd3},
        '{16'd4,     1'b1, 16'd3},
        '{16'd5,     1'b0, 16'd0},
        '{16'd6,     1'b0, 16'd0},
        '{16'd9,     1'b0, 16'd0},
        '{16'd49,    1'b0, 16'd0},
        '{16'd121,   1'b0, 16'd0},
        '{16'hFFFF,  1'b1, 16'd65521},
        '{16'd65521, 1'b1, 16'd65521},
        '{16'd65520, 1'b0, 16'd0},
        '{16'd63001, 1'b0, 16'd0},
        '{16'd31468, 1'b0, 16'd0},
        '{16'h8000,  1'b0, 16'd0},
        '{16'h7FFF,  1'b0, 16'd0},
        '{16'hAAAA,  1'b0, 16'd0},
        '{16'h5555,  1'b0, 16'd0},
        '{16'd65025, 1'b0, 16'd0}
    };

    logic         clk;
    logic         rst_n;
    logic         start;
    logic         busy;
    logic [W-1:0] upper_limit;
    logic         done;
    logic [W-1:0] largest_prime;

    logic [W-1:0] expected_primes [$];
    logic [W-1:0] oldest_prime;
    int           mismatch_count;
    int           cycle_count;

    largest_prime_at_most_core #(
        .VALUE_WIDTH(W)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .upper_limit  (upper_limit),
        .done         (done),
        .largest_prime(largest_prime)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // trial division from the limit downward
    function automatic logic [W-1:0] largest_prime_upto(input logic [W-1:0] lim);
        int unsigned cand;
        int unsigned divisor;
        bit          is_prime;
        cand = 32'(lim);
        while (cand >= 2)
        begin
            is_prime = 1'b1;
            for (divisor = 2; divisor * divisor <= cand; divisor++)
            begin
                if (cand % divisor == 0)
                begin
                    is_prime = 1'b0;
                    break;
                end
            end
            if (is_prime)
                return cand[W-1:0];
            cand--;
        end
        return W'(1);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // start stays high across back-to-back words, so only one assignment per edge
    task automatic send_limit(input logic [W-1:0] lim, input int gap,
                              input bit known, input logic [W-1:0] want);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        upper_limit <= lim;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        expected_primes.push_back(known ? want : largest_prime_upto(lim));
    endtask

    task automatic wait_results_drained();
        while (expected_primes.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            if (expected_primes.size() == 0)
                report_mismatch($sformatf("result %0d with nothing outstanding", largest_prime));
            else
            begin
                oldest_prime = expected_primes.pop_front();
                if (largest_prime !== oldest_prime)
                    report_mismatch($sformatf("largest_prime %0d, want %0d",
                                              largest_prime, oldest_prime));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_largest_prime_at_most_core failed");
            $finish;
        end
    end

    initial
    begin
        int          pick;
        int          gap;
        logic [W-1:0] lim;
        rst_n          = 1'b0;
        start          = 1'b0;
        upper_limit    = '0;
        mismatch_count = 0;
        cycle_count    = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
            send_limit(directed_cases[i].limit, $urandom_range(0, 6),
                       directed_cases[i].known, directed_cases[i].prime);

        // hold off until the block has answered everything
        start <= 1'b0;
        @(posedge clk);
        wait_results_drained();

        for (int k = 0; k < RANDOM_WORDS; k++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 5)
                lim = W'($urandom_range(0, 65535));
            else if (pick < 8)
                lim = W'($urandom_range(0, 300));
            else
                lim = W'($urandom_range(60000, 65535));
            // every third block of ten runs back to back
            gap = ((k / 10) % 3 == 1) ? 0 : $urandom_range(0, 6);
            if (k == RANDOM_WORDS / 2)
            begin
                start <= 1'b0;
                @(posedge clk);
                wait_results_drained();
                gap = 0;
            end
            send_limit(lim, gap, 1'b0, '0);
        end
        start <= 1'b0;

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_largest_prime_at_most_core passed");
        else
            $display("tb_largest_prime_at_most_core failed");
        $finish;
    end

endmodule
